### hdl/lpxfp_pkg.sv
// package for the length-prefixed xor frame parser
// holds the queue entry and result types, op codes and result kinds
// no dependencies
`default_nettype none

package lpxfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned OP_W   = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BODY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LEN_ERR = 2'd3;

  // ops handed from front to back
  localparam logic [OP_W-1:0] OP_SEED    = 3'd0;
  localparam logic [OP_W-1:0] OP_MIX     = 3'd1;
  localparam logic [OP_W-1:0] OP_BODY    = 3'd2;
  localparam logic [OP_W-1:0] OP_END     = 3'd3;
  localparam logic [OP_W-1:0] OP_LEN_ERR = 3'd4;

  // register indexes (byte address bit 2)
  localparam logic REG_SYNC    = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'h7F;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd2048;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  index;
    logic [LEN_W-1:0]  length;
  } lpxfp_op_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  index;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] check;
  } lpxfp_res_t;

endpackage

`default_nettype wire

### hdl/lpxfp_front.sv
// front end: accepts bytes, tracks the frame phase, length and body count
// and turns each sync or frame byte into an op for the back end; uses lpxfp_pkg
`default_nettype none

module lpxfp_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire  [lpxfp_pkg::BYTE_W-1:0] sync_byte,
  input  wire  [lpxfp_pkg::LEN_W-1:0]  max_length,
  input  wire                        in_valid,
  input  wire  [lpxfp_pkg::BYTE_W-1:0] in_byte,
  output logic                       in_ready,
  input  wire                        q_full,
  output logic                       push,
  output lpxfp_pkg::lpxfp_op_t       push_op
);
  import lpxfp_pkg::*;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_full;
  logic [LEN_W-1:0] cnt_inc;
  logic             acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign len_full = {len_r[LEN_W-1:BYTE_W], in_byte};
  assign cnt_inc  = cnt_r + LEN_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    push           = 1'b0;
    push_op.op     = OP_MIX;
    push_op.data   = in_byte;
    push_op.index  = '0;
    push_op.length = len_r;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_byte == sync_byte) begin
            push       = 1'b1;
            push_op.op = OP_SEED;
            phase_nxt  = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          push      = 1'b1;
          len_nxt   = {in_byte, {BYTE_W{1'b0}}};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          push           = 1'b1;
          len_nxt        = len_full;
          push_op.length = len_full;
          cnt_nxt        = '0;
          if (len_full == '0 || len_full > max_length) begin
            push_op.op = OP_LEN_ERR;
            len_nxt    = '0;
            phase_nxt  = PH_HUNT;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          push = 1'b1;
          if (cnt_inc >= len_r) begin
            push_op.op = OP_END;
            len_nxt    = '0;
            cnt_nxt    = '0;
            phase_nxt  = PH_HUNT;
          end else begin
            push_op.op    = OP_BODY;
            push_op.index = cnt_r;
            cnt_nxt       = cnt_inc;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // body count stays below the length while a body is open
  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (cnt_r < len_r))
    else $error("body count reached frame length");

endmodule

`default_nettype wire

### hdl/lpxfp_queue.sv
// short op queue between front and back end
// register file with head and tail pointers; uses lpxfp_pkg
`default_nettype none

module lpxfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  lpxfp_pkg::lpxfp_op_t push_op,
  output logic                 full,
  input  wire                  pop,
  output logic                 head_valid,
  output lpxfp_pkg::lpxfp_op_t head_op
);
  import lpxfp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lpxfp_op_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("op pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

### hdl/lpxfp_back.sv
// back end: applies ops to the running xor and saved command,
// builds result items and holds them in the output register; uses lpxfp_pkg
`default_nettype none

module lpxfp_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  head_valid,
  input  lpxfp_pkg::lpxfp_op_t head_op,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lpxfp_pkg::lpxfp_res_t out_res
);
  import lpxfp_pkg::*;

  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic              valid_r, valid_nxt;
  lpxfp_res_t        res_r, res_nxt;
  logic              has_res;
  logic [BYTE_W-1:0] cmd_cur;
  logic [BYTE_W-1:0] xor_mix;

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign cmd_cur   = (head_op.index == '0) ? head_op.data : cmd_r;
  assign xor_mix   = xor_r ^ head_op.data;

  always_comb begin
    case (head_op.op)
      OP_BODY, OP_END, OP_LEN_ERR: has_res = 1'b1;
      default:                     has_res = 1'b0;
    endcase
  end

  // ops without a result never wait for the output slot
  assign pop = head_valid && (!has_res || !valid_r || out_ready);

  always_comb begin
    xor_nxt        = xor_r;
    cmd_nxt        = cmd_r;
    res_nxt        = res_r;
    valid_nxt      = valid_r && !out_ready;
    if (pop) begin
      case (head_op.op)
        OP_SEED: begin
          xor_nxt = head_op.data;
        end
        OP_MIX: begin
          xor_nxt = xor_mix;
        end
        OP_BODY: begin
          xor_nxt         = xor_mix;
          cmd_nxt         = cmd_cur;
          valid_nxt       = 1'b1;
          res_nxt.kind    = KIND_BODY;
          res_nxt.data    = head_op.data;
          res_nxt.index   = head_op.index;
          res_nxt.command = cmd_cur;
          res_nxt.length  = head_op.length;
          res_nxt.check   = xor_mix;
        end
        OP_END: begin
          xor_nxt         = '0;
          cmd_nxt         = '0;
          valid_nxt       = 1'b1;
          res_nxt.kind    = (head_op.data == xor_r) ? KIND_GOOD : KIND_BAD;
          res_nxt.data    = head_op.data;
          res_nxt.index   = '0;
          res_nxt.command = cmd_r;
          res_nxt.length  = head_op.length;
          res_nxt.check   = xor_r;
        end
        OP_LEN_ERR: begin
          xor_nxt         = '0;
          cmd_nxt         = '0;
          valid_nxt       = 1'b1;
          res_nxt.kind    = KIND_LEN_ERR;
          res_nxt.data    = '0;
          res_nxt.index   = '0;
          res_nxt.command = '0;
          res_nxt.length  = head_op.length;
          res_nxt.check   = '0;
        end
        default: begin
          xor_nxt = xor_r;
        end
      endcase
    end else begin
      res_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r   <= '0;
      cmd_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      xor_r   <= xor_nxt;
      cmd_r   <= cmd_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // a new result only lands in a free or draining output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && has_res && valid_r) |-> out_ready)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### hdl/length_prefixed_xor_frame_parser.sv
// top level of the length-prefixed xor frame parser: config registers,
// front end, op queue and back end; uses lpxfp_pkg, lpxfp_front,
// lpxfp_queue and lpxfp_back
//
//  port group  | dir | carries
//  in_*        | in  | one received byte per item (tdata[7:0])
//  out_*       | out | body byte, frame good/bad or length error item
//  cfg_*       | in  | sync_byte at 0x0, max_length at 0x4
//
// one byte accepted per cycle while the queue is not full; its op is queued and
// its result registered; front decides each byte's role, back applies it on pop
// sync reset clears the frame state, the queue and the output valid flag and
// loads sync_byte 0x7F and max_length 2048
// a stalled output fills the QUEUE_DEPTH entry queue, then in_tready drops
`default_nettype none

module length_prefixed_xor_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // out_byte, byte_index, command_byte,
                                  // frame_length, computed_check
  output logic [1:0]  out_tuser,  // out_kind
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lpxfp_pkg::*;

  logic [BYTE_W-1:0] sync_r;
  logic [LEN_W-1:0]  max_len_r;
  logic              cfg_wr;
  logic              q_full;
  logic              push;
  lpxfp_op_t         push_op;
  logic              pop;
  logic              head_valid;
  lpxfp_op_t         head_op;
  lpxfp_res_t        res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= SYNC_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SYNC) begin
        sync_r <= cfg_pwdata[BYTE_W-1:0];
      end else begin
        max_len_r <= cfg_pwdata[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_MAX_LEN) begin
      cfg_prdata = {{(32 - LEN_W){1'b0}}, max_len_r};
    end else begin
      cfg_prdata = {{(32 - BYTE_W){1'b0}}, sync_r};
    end
  end

  lpxfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .sync_byte  (sync_r),
    .max_length (max_len_r),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  lpxfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  lpxfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {res.check, res.length, res.command, res.index, res.data};

endmodule

`default_nettype wire

### tb/length_prefixed_xor_frame_parser_tb.sv
// self-checking bench for length_prefixed_xor_frame_parser: table-driven and random
// byte streams with an in-bench frame parser model; needs lpxfp_pkg and the dut
`default_nettype none

module length_prefixed_xor_frame_parser_tb;
  import lpxfp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam lpxfp_res_t NO_RES = '0;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY} parse_phase_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    logic       has;
    lpxfp_res_t want;
  } rx_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;           // out_byte, byte_index, command_byte,
                                    // frame_length, computed_check
  logic [1:0]  out_tuser;           // out_kind
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  length_prefixed_xor_frame_parser dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #1 clk = ~clk;

  // parser model state and register shadows
  logic [7:0]   sync_reg = SYNC_RESET;
  logic [15:0]  max_len_reg = MAX_LEN_RESET;
  parse_phase_t parse_phase = PH_HUNT;
  logic [15:0]  len_field = '0;
  logic [15:0]  body_count = '0;
  logic [7:0]   run_xor = '0;
  logic [7:0]   saved_cmd = '0;

  lpxfp_res_t  awaited_results[$];
  rx_row_t     pinned_rows[$];
  logic [7:0]  rx_stream[$];

  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned body_items = 0;
  int unsigned good_frames = 0;
  int unsigned bad_frames = 0;
  int unsigned len_errors = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cycles = 0;

  rx_row_t directed_rows [0:20] = '{
    '{8'h00, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES},
    '{8'h7F, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{KIND_LEN_ERR, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00}},
    '{8'h7F, 1'b1, 1'b0, NO_RES},
    '{8'h08, 1'b1, 1'b0, NO_RES},
    '{8'h01, 1'b1, 1'b1, '{KIND_LEN_ERR, 8'h00, 16'h0000, 8'h00, 16'h0801, 8'h00}},
    '{8'h7F, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b0, NO_RES},
    '{8'h01, 1'b1, 1'b0, NO_RES},
    '{8'h7E, 1'b1, 1'b1, '{KIND_GOOD, 8'h7E, 16'h0000, 8'h00, 16'h0001, 8'h7E}},
    '{8'h7F, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{KIND_LEN_ERR, 8'h00, 16'h0000, 8'h00, 16'hFFFF, 8'h00}}
  };

  function automatic void clear_frame();
    parse_phase = PH_HUNT;
    len_field = '0;
    body_count = '0;
    run_xor = '0;
    saved_cmd = '0;
  endfunction

  function automatic bit advance_parser(input logic [7:0] b, output lpxfp_res_t r);
    r = NO_RES;
    case (parse_phase)
      PH_HUNT: begin
        if (b == sync_reg) begin
          run_xor = b;
          parse_phase = PH_LEN_HI;
        end
        return 1'b0;
      end
      PH_LEN_HI: begin
        len_field = {b, 8'h00};
        run_xor ^= b;
        parse_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        len_field[7:0] = b;
        run_xor ^= b;
        body_count = '0;
        if (len_field == 16'd0 || len_field > max_len_reg) begin
          r.kind = KIND_LEN_ERR;
          r.length = len_field;
          clear_frame();
          return 1'b1;
        end
        parse_phase = PH_BODY;
        return 1'b0;
      end
      default: begin
        body_count = body_count + 16'd1;
        if (body_count >= len_field) begin
          r.kind = (b == run_xor) ? KIND_GOOD : KIND_BAD;
          r.data = b;
          r.command = saved_cmd;
          r.length = len_field;
          r.check = run_xor;
          clear_frame();
          return 1'b1;
        end
        if (body_count == 16'd1) saved_cmd = b;
        run_xor ^= b;
        r.kind = KIND_BODY;
        r.data = b;
        r.index = body_count - 16'd1;
        r.command = saved_cmd;
        r.length = len_field;
        r.check = run_xor;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    fail_count++;
  endtask

  // model runs at the accepting edge, checker compares in arrival order
  always @(posedge clk) begin : scoreboard
    rx_row_t    row;
    lpxfp_res_t res;
    lpxfp_res_t got;
    bit         has;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        row = (pinned_rows.size() != 0) ? pinned_rows.pop_front() : '0;
        has = advance_parser(in_tdata, res);
        if (row.pinned) begin
          has = row.has;
          res = row.want;
        end
        if (has) awaited_results.push_back(res);
      end
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.data = out_tdata[7:0];
        got.index = out_tdata[23:8];
        got.command = out_tdata[31:24];
        got.length = out_tdata[47:32];
        got.check = out_tdata[55:48];
        results_seen++;
        case (got.kind)
          KIND_BODY: body_items++;
          KIND_GOOD: good_frames++;
          KIND_BAD: bad_frames++;
          default: len_errors++;
        endcase
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected item: expected none actual %h/%h", $time,
                   got.kind, out_tdata);
          fail_count++;
        end else begin
          res = awaited_results.pop_front();
          if (got.kind !== res.kind)
            report_field("out_kind", 32'(res.kind), 32'(got.kind));
          if (got.data !== res.data)
            report_field("out_byte", 32'(res.data), 32'(got.data));
          if (got.index !== res.index)
            report_field("byte_index", 32'(res.index), 32'(got.index));
          if (got.command !== res.command)
            report_field("command_byte", 32'(res.command), 32'(got.command));
          if (got.length !== res.length)
            report_field("frame_length", 32'(res.length), 32'(got.length));
          if (got.check !== res.check)
            report_field("computed_check", 32'(res.check), 32'(got.check));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver: segments of steady, random and sparse ready, one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned seg;
    bit          held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 60) begin
        out_tready <= 1'b0;
        repeat (150) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 2);
      seg = $urandom_range(5, 40);
      repeat (seg) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_byte(input rx_row_t row);
    pinned_rows.push_back(row);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= row.rx;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // feed filler until the model is back to hunting
  task automatic close_frame();
    rx_row_t row;
    row = '0;
    forever begin
      @(negedge clk);
      if (parse_phase == PH_HUNT) break;
      row.rx = (parse_phase == PH_LEN_HI) ? 8'h00 : 8'($urandom);
      @(posedge clk);
      send_byte(row);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (awaited_results.size() != 0 || pinned_rows.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_stream();
    rx_row_t row;
    row = '0;
    @(posedge clk);
    foreach (rx_stream[i]) begin
      row.rx = rx_stream[i];
      send_byte(row);
    end
    in_tvalid <= 1'b0;
    close_frame();
    drain();
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_SYNC) sync_reg = value[7:0];
    else max_len_reg = value[15:0];
  endtask

  function automatic int unsigned pick_length();
    int unsigned lim;
    int unsigned cap;
    int unsigned pick;
    lim = 32'(max_len_reg);
    if (lim == 0) return $urandom_range(0, 65535);
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1 && lim < 65535)
      return $urandom_range(lim + 1, (lim + 300 > 65535) ? 65535 : lim + 300);
    cap = (pick == 2) ? 40 : 10;
    if (cap > lim) cap = lim;
    return $urandom_range(1, cap);
  endfunction

  // mostly well-formed frames, some bad checksums, truncated frames and noise
  task automatic build_stream(input int unsigned n);
    int unsigned shape;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  acc;
    logic [7:0]  b;
    rx_stream.delete();
    while (rx_stream.size() < n) begin
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom));
      end else begin
        len = pick_length();
        acc = sync_reg ^ len[15:8] ^ len[7:0];
        rx_stream.push_back(sync_reg);
        rx_stream.push_back(len[15:8]);
        rx_stream.push_back(len[7:0]);
        if (len != 0 && len <= max_len_reg) begin
          cut = (shape == 1) ? $urandom_range(0, len - 1) : len - 1;
          repeat (cut) begin
            b = 8'($urandom);
            acc ^= b;
            rx_stream.push_back(b);
          end
          if (shape == 2) rx_stream.push_back(acc ^ 8'($urandom_range(1, 255)));
          else if (shape != 1) rx_stream.push_back(acc);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    in_tvalid <= 1'b0;
    close_frame();
    drain();

    build_stream(150);
    send_stream();

    cfg_write(REG_SYNC, 32'h0000_0000);
    cfg_write(REG_MAX_LEN, 32'h0000_0001);
    build_stream(100);
    send_stream();

    cfg_write(REG_SYNC, 32'h0000_00FF);
    cfg_write(REG_MAX_LEN, 32'h0000_FFFF);
    build_stream(150);
    send_stream();

    cfg_write(REG_SYNC, 32'($urandom_range(0, 255)));
    cfg_write(REG_MAX_LEN, 32'h0000_0000);
    build_stream(50);
    send_stream();

    cfg_write(REG_SYNC, 32'($urandom_range(0, 255)));
    cfg_write(REG_MAX_LEN, 32'd16);
    build_stream(180);
    send_stream();

    if (awaited_results.size() != 0) begin
      $display("%0t %0d expected items never arrived", $time, awaited_results.size());
      fail_count++;
    end
    $display("sent %0d rx bytes over five register settings (max_length 0, 1, 16, 2048, 65535)",
             bytes_sent);
    $display("checked %0d body items, %0d good, %0d bad, %0d length errors, %0d mismatches",
             body_items, good_frames, bad_frames, len_errors, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
